// ----- rtl/rcd_pkg.sv -----
// Package for the rotating card deque: sizes, command, status and cell-select codes.
// It also holds the control struct passed from the top level to each storage cell.
// Depends on nothing.
package rcd_pkg;

  localparam int DECK_DEPTH  = 64;
  localparam int VALUE_WIDTH = 16;
  localparam int FIELD_W     = 16;
  localparam int IDX_W       = (DECK_DEPTH > 1) ? $clog2(DECK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(DECK_DEPTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [FIELD_W-1:0]     field_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [IDX_W-1:0]       index_t;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_BOT2TOP = 2'd2;
  localparam logic [1:0] CMD_TOP2BOT = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] SEL_HOLD   = 2'd0;
  localparam logic [1:0] SEL_ABOVE  = 2'd1;
  localparam logic [1:0] SEL_BELOW  = 2'd2;
  localparam logic [1:0] SEL_INJECT = 2'd3;

  typedef struct packed {
    logic [1:0] sel;
    logic       is_bottom;
  } cell_ctrl_t;

endpackage

// ----- rtl/rcd_cell.sv -----
// One storage cell of the card chain: holds a single card value.
// Loads from the cell above, the cell below or the injected value. Uses rcd_pkg.
module rcd_cell (
  input  logic                clk,
  input  rcd_pkg::cell_ctrl_t ctrl,
  input  rcd_pkg::value_t     above,
  input  rcd_pkg::value_t     below,
  input  rcd_pkg::value_t     inject,
  output rcd_pkg::value_t     value,
  output rcd_pkg::value_t     tap
);

  rcd_pkg::value_t value_next;

  always_comb begin
    unique case (ctrl.sel)
      rcd_pkg::SEL_ABOVE:  value_next = above;
      rcd_pkg::SEL_BELOW:  value_next = below;
      rcd_pkg::SEL_INJECT: value_next = inject;
      default:             value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign tap = ctrl.is_bottom ? value : '0;

endmodule

// ----- rtl/rotating_card_deque.sv -----
// Top level of the rotating card deque: a chain of card cells with the top card in cell 0.
// Decodes each request into per-cell selects and registers one result. Uses rcd_pkg, rcd_cell.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   request  | in_valid / in_stall  | command, card_value
//   result   | out_valid / out_stall| status, popped_value, now_empty
//
// Each request's result is registered and shows in the cycle after the request is taken.
// A new request is taken each cycle unless a waiting result is stalled.
// The bottom card reaches the top through a one-hot OR of the cell taps.
// Reset clears the card count and the result valid; cell contents need no reset.
module rotating_card_deque (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  rcd_pkg::field_t       card_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output rcd_pkg::field_t       popped_value,
  output logic                  now_empty
);

  localparam int N = rcd_pkg::DECK_DEPTH;

  rcd_pkg::count_t     count;
  rcd_pkg::count_t     count_next;
  rcd_pkg::count_t     count_m1;
  rcd_pkg::index_t     bottom_idx;
  rcd_pkg::cell_ctrl_t ctrl [N];
  rcd_pkg::value_t     cell_v [N];
  rcd_pkg::value_t     tap_v [N];
  rcd_pkg::value_t     above_v [N];
  rcd_pkg::value_t     below_v [N];
  rcd_pkg::value_t     inject;
  rcd_pkg::value_t     bottom_val;
  logic [1:0]          status_next;
  rcd_pkg::field_t     popped_next;
  logic                accept;
  logic                is_empty;
  logic                is_full;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_empty = (count == '0);
  assign is_full  = (count == rcd_pkg::CNT_W'(N));
  assign count_m1   = count - rcd_pkg::CNT_W'(1);
  assign bottom_idx = count_m1[rcd_pkg::IDX_W-1:0];

  always_comb begin
    bottom_val = '0;
    for (int i = 0; i < N; i++) begin
      bottom_val = bottom_val | tap_v[i];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = rcd_pkg::ST_DONE;
    popped_next = '0;
    inject      = rcd_pkg::value_t'(card_value);
    for (int i = 0; i < N; i++) begin
      ctrl[i].sel       = rcd_pkg::SEL_HOLD;
      ctrl[i].is_bottom = !is_empty && (bottom_idx == rcd_pkg::IDX_W'(i));
    end
    if (accept) begin
      if (command == rcd_pkg::CMD_PUSH) begin
        if (is_full) begin
          status_next = rcd_pkg::ST_FULL;
        end else begin
          count_next = count + rcd_pkg::CNT_W'(1);
          for (int i = 0; i < N; i++) begin
            ctrl[i].sel = (i == 0) ? rcd_pkg::SEL_INJECT : rcd_pkg::SEL_ABOVE;
          end
        end
      end else if (is_empty) begin
        status_next = rcd_pkg::ST_EMPTY;
      end else begin
        unique case (command)
          rcd_pkg::CMD_POP: begin
            popped_next = rcd_pkg::FIELD_W'(cell_v[0]);
            count_next  = count_m1;
            for (int i = 0; i < N; i++) begin
              ctrl[i].sel = rcd_pkg::SEL_BELOW;
            end
          end
          rcd_pkg::CMD_BOT2TOP: begin
            inject = bottom_val;
            for (int i = 0; i < N; i++) begin
              ctrl[i].sel = (i == 0) ? rcd_pkg::SEL_INJECT : rcd_pkg::SEL_ABOVE;
            end
          end
          default: begin
            inject = cell_v[0];
            for (int i = 0; i < N; i++) begin
              ctrl[i].sel = ctrl[i].is_bottom ? rcd_pkg::SEL_INJECT : rcd_pkg::SEL_BELOW;
            end
          end
        endcase
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign above_v[g] = inject;
    end else begin : g_mid
      assign above_v[g] = cell_v[g-1];
    end
    if (g == N - 1) begin : g_last
      assign below_v[g] = cell_v[g];
    end else begin : g_inner
      assign below_v[g] = cell_v[g+1];
    end
    rcd_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl[g]),
      .above  (above_v[g]),
      .below  (below_v[g]),
      .inject (inject),
      .value  (cell_v[g]),
      .tap    (tap_v[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= status_next;
      popped_value <= popped_next;
      now_empty    <= (count_next == '0);
    end
  end

endmodule
